// ===== hw/rtl/crlf_pkg.sv =====
package crlf_pkg;

    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_SP      = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_PCT     = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_DASH    = 8'h2d;
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_H   = 8'h68;
    localparam logic [7:0] CH_LOW_P   = 8'h70;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    // offsets in the header tracker stay below SKIP_REACH + 2 <= 66
    localparam int OFF_W = 7;

    // number of history cells behind the newest byte
    localparam int NUM_CELLS = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       vld;
        logic       elig;
    } cell_t;

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = ((c | CASE_BIT) >= CH_LOW_A) && ((c | CASE_BIT) <= 8'h7a);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        is_name_char = is_alpha(c) || (c >= CH_ZERO && c <= 8'h39) ||
                       c == CH_DASH || c == CH_UNDER;
    endfunction

endpackage

// ===== hw/rtl/crlf_header_injection_scan.sv =====
// Response-splitting scanner. Takes one string byte per clock while s_ready
// is high and, on the byte flagged last, returns one detected flag. Matching
// is streaming over a row of eight byte cells plus a small header tracker,
// so one transaction can be accepted every clock while the result register
// is free or being drained. Bytes past MAX_SCAN plus the lookahead span are
// not inspected; the verdict still arrives on the last byte.
module crlf_header_injection_scan
    import crlf_pkg::*;
#(
    parameter int MAX_SCAN     = 4096,
    parameter int SKIP_REACH   = 64,
    parameter int HEADER_REACH = 30
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_detected
);

    localparam int LOOK_RAW  = SKIP_REACH + HEADER_REACH - 2;
    localparam int LOOKAHEAD = (LOOK_RAW > 6) ? LOOK_RAW : 6;
    localparam int CAP       = MAX_SCAN + LOOKAHEAD;
    localparam int POS_W     = $clog2(CAP + 1);

    logic [POS_W-1:0] pos_reg;
    logic             hit_reg;
    logic             m_valid_reg;
    logic             m_detected_reg;

    logic  s_fire, stored, elig, shift_en;
    logic  hit_pct, hit_crlf_http, hit_ver, hit_hdr, hit_now;
    cell_t w [NUM_CELLS+1];

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign stored   = pos_reg < POS_W'(CAP);
    assign elig     = pos_reg < POS_W'(MAX_SCAN);
    assign shift_en = s_fire && stored;

    assign w[0] = '{data: s_data_byte, vld: 1'b1, elig: elig};

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        crlf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (shift_en),
            .clear    (s_fire && s_last),
            .cell_in  (w[k]),
            .cell_out (w[k+1])
        );
    end

    crlf_hdr #(
        .SKIP_REACH   (SKIP_REACH),
        .HEADER_REACH (HEADER_REACH)
    ) u_hdr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (s_fire),
        .clear   (s_last),
        .data    (s_data_byte),
        .lf_elig (elig),
        .prev    (w[1]),
        .hit     (hit_hdr)
    );

    // "%0d" / "%0a"
    assign hit_pct = w[2].vld && w[2].elig && w[2].data == CH_PCT && w[1].data == CH_ZERO &&
                     ((w[0].data | CASE_BIT) == CH_LOW_D || (w[0].data | CASE_BIT) == CH_LOW_A);

    // CR LF http/ (the "h" must lie inside the skip reach)
    assign hit_crlf_http = (SKIP_REACH > 2) &&
                           w[6].vld && w[6].elig && w[6].data == CH_CR && w[5].data == CH_LF &&
                           (w[4].data | CASE_BIT) == CH_LOW_H &&
                           (w[3].data | CASE_BIT) == CH_LOW_T &&
                           (w[2].data | CASE_BIT) == CH_LOW_T &&
                           (w[1].data | CASE_BIT) == CH_LOW_P && w[0].data == CH_SLASH;

    // http/[01]. at string start or after CR, LF or "%0"
    assign hit_ver = w[6].vld && w[6].elig &&
                     (w[6].data | CASE_BIT) == CH_LOW_H && (w[5].data | CASE_BIT) == CH_LOW_T &&
                     (w[4].data | CASE_BIT) == CH_LOW_T && (w[3].data | CASE_BIT) == CH_LOW_P &&
                     w[2].data == CH_SLASH &&
                     (w[1].data == CH_ZERO || w[1].data == CH_ONE) && w[0].data == CH_DOT &&
                     (!w[7].vld || w[7].data == CH_CR || w[7].data == CH_LF ||
                      (w[8].vld && w[8].data == CH_PCT && w[7].data == CH_ZERO));

    assign hit_now = stored && (hit_pct || hit_crlf_http || hit_ver || hit_hdr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_fire) begin
                if (s_last) begin
                    pos_reg        <= '0;
                    hit_reg        <= 1'b0;
                    m_valid_reg    <= 1'b1;
                    m_detected_reg <= hit_reg || hit_now;
                end else begin
                    if (stored) begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                    hit_reg <= hit_reg || hit_now;
                end
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_detected = m_detected_reg;

    a_pos_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last |=> pos_reg == '0 && !hit_reg)
        else $error("position or hit not cleared after verdict");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg)
        else $error("input stalled with empty result register");

    a_verdict_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_last |=> m_valid_reg)
        else $error("verdict not presented after last byte");

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(CAP))
        else $error("byte position beyond cap");

endmodule

// ===== hw/rtl/crlf_cell.sv =====
module crlf_cell
    import crlf_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  shift_en,
    input  logic  clear,
    input  cell_t cell_in,
    output cell_t cell_out
);

    logic [7:0] data_reg;
    logic       vld_reg;
    logic       elig_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= 1'b0;
            elig_reg <= 1'b0;
        end else if (clear) begin
            vld_reg  <= 1'b0;
            elig_reg <= 1'b0;
        end else if (shift_en) begin
            vld_reg  <= cell_in.vld;
            elig_reg <= cell_in.elig;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= cell_in.data;
        end
    end

    assign cell_out = '{data: data_reg, vld: vld_reg, elig: elig_reg};

endmodule

// ===== hw/rtl/crlf_hdr.sv =====
module crlf_hdr
    import crlf_pkg::*;
#(
    parameter int SKIP_REACH   = 64,
    parameter int HEADER_REACH = 30
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       clear,
    input  logic [7:0] data,
    input  logic       lf_elig,
    input  cell_t      prev,
    output logic       hit
);

    typedef enum logic [1:0] {ST_IDLE, ST_BLANK, ST_NAME} state_t;

    state_t           state_reg, state_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic             strict_reg, strict_next;
    logic             cr_elig;

    assign cr_elig = prev.vld && prev.elig && prev.data == CH_CR;

    always_comb begin
        state_next  = state_reg;
        off_next    = off_reg;
        strict_next = strict_reg;
        hit         = 1'b0;
        if (data == CH_LF) begin
            // lone LF wins over CR LF: its skip limit is one further
            state_next  = (lf_elig || cr_elig) ? ST_BLANK : ST_IDLE;
            strict_next = !lf_elig;
            off_next    = OFF_W'(1);
        end else begin
            case (state_reg)
                ST_BLANK: begin
                    if (int'(off_reg) + int'(strict_reg) >= SKIP_REACH) begin
                        state_next = ST_IDLE;
                    end else if (data == CH_SP || data == CH_TAB) begin
                        off_next = off_reg + OFF_W'(1);
                    end else if (is_alpha(data)) begin
                        state_next = ST_NAME;
                        off_next   = OFF_W'(1);
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
                ST_NAME: begin
                    if (int'(off_reg) >= HEADER_REACH) begin
                        state_next = ST_IDLE;
                    end else if (data == CH_COLON) begin
                        hit        = 1'b1;
                        state_next = ST_IDLE;
                    end else if (is_name_char(data)) begin
                        off_next = off_reg + OFF_W'(1);
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            off_reg    <= '0;
            strict_reg <= 1'b0;
        end else if (en && clear) begin
            state_reg <= ST_IDLE;
        end else if (en) begin
            state_reg  <= state_next;
            off_reg    <= off_next;
            strict_reg <= strict_next;
        end
    end

endmodule
